[hw/rtl/ecp_pkg.sv]
package ecp_pkg;

  localparam int POS_W   = 32;
  localparam int D_W     = POS_W + 1;
  localparam int AX_W    = 19;
  localparam int PR_W    = D_W + AX_W;
  localparam int SUM_W   = PR_W + 3;
  localparam int V_W     = SUM_W - 16;
  localparam int VZ_W    = V_W - 1;
  localparam int FOC_W   = 30;
  localparam int FL_W    = FOC_W / 2;
  localparam int PP_W    = V_W + FL_W + 1;
  localparam int N_W     = PP_W + FL_W + 1;
  localparam int QB      = 25;
  localparam int QS_W    = QB + 2;
  localparam int OS_W    = QS_W + 1;
  localparam int OUT_W   = 24;
  localparam int ANG_W   = 16;
  localparam int CX_W    = 33;
  localparam int CZ_W    = 27;
  localparam int FN_W    = 52;
  localparam int CORDIC_N = 18;
  localparam int ADDR_W  = 5;

  localparam logic [ANG_W-1:0] FOV_MIN   = 16'd256;
  localparam logic [ANG_W-1:0] FOV_MAX   = 16'd45824;
  localparam logic [ANG_W-1:0] FOV_RESET = 16'd23040;
  localparam logic signed [CX_W-1:0] CORDIC_K = 33'sd652032874;
  localparam logic signed [CZ_W-1:0] DEG90  = 27'sd5898240;
  localparam logic signed [CZ_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [CZ_W-1:0] DEG360 = 27'sd23592960;
  localparam logic signed [OS_W-1:0] OUT_MAX = 28'sd8388607;
  localparam logic signed [OS_W-1:0] OUT_MIN = -28'sd8388608;

  localparam logic [2:0] REG_CAM_X = 3'd0;
  localparam logic [2:0] REG_CAM_Y = 3'd1;
  localparam logic [2:0] REG_CAM_Z = 3'd2;
  localparam logic [2:0] REG_PITCH = 3'd3;
  localparam logic [2:0] REG_YAW   = 3'd4;
  localparam logic [2:0] REG_ROLL  = 3'd5;
  localparam logic [2:0] REG_FOV   = 3'd6;

  typedef struct packed {
    logic signed [POS_W-1:0] world_x;
    logic signed [POS_W-1:0] world_y;
    logic signed [POS_W-1:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic                    depth_clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [AX_W-1:0] ax0;
    logic signed [AX_W-1:0] ax1;
    logic signed [AX_W-1:0] ax2;
    logic signed [AX_W-1:0] ay0;
    logic signed [AX_W-1:0] ay1;
    logic signed [AX_W-1:0] ay2;
    logic signed [AX_W-1:0] az0;
    logic signed [AX_W-1:0] az1;
    logic signed [AX_W-1:0] az2;
    logic [FOC_W-1:0]       focal;
  } cam_t;

  function automatic logic signed [CZ_W-1:0] atan_q16(input logic [4:0] i);
    logic signed [CZ_W-1:0] v;
    unique case (i)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/euler_camera_projection.sv]
// Channel   Ports                                  Handshake
// input     start, busy, in_data                   taken when start is high and busy low
// result    out_valid, out_data                    one cycle per result, no back pressure
// config    psel penable pwrite paddr pwdata       written in the access cycle, pready high
//           prdata pready
//
// One request is taken every cycle while busy is low.
// After reset, and after every register write, the camera setup runs with busy high
// (four 18-step CORDIC passes, 14 products and a 52-step focal divide).
// The pipeline never stalls, since results cannot be held off by the receiver.
module euler_camera_projection
  import ecp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic signed [OS_W-1:0] HW_S = OS_W'(SCREEN_WIDTH * 128);
  localparam logic signed [OS_W-1:0] HH_S = OS_W'(SCREEN_HEIGHT * 128);

  logic signed [POS_W-1:0] camx_r, camy_r, camz_r;
  logic [ANG_W-1:0]        pitch_r, yaw_r, roll_r, fov_r;
  logic                    wr;
  logic [2:0]              ridx;
  logic                    setup_busy;
  cam_t                    cam;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [D_W-1:0]   d_r [3];
  logic signed [PR_W-1:0]  pr_r [9];
  logic signed [V_W-1:0]   vx_r, vy_r;
  logic [VZ_W-1:0]         vz3_r, vz4_r, vz5_r;
  logic                    cl3_r, cl4_r, cl5_r;
  logic signed [PP_W-1:0]  pxl_r, pxh_r, pyl_r, pyh_r;
  logic signed [N_W-1:0]   nx_r, ny_r;
  out_item_t               out_r;

  logic signed [SUM_W-1:0] sx, sy, sz;
  logic signed [V_W-1:0]   vx_c, vy_c, vz_c;
  logic signed [FL_W:0]    flo, fhi;
  logic                    dv;
  logic signed [QS_W-1:0]  qx, qy;
  logic                    dcl;
  logic signed [OS_W-1:0]  px, py;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camx_r  <= '0;
      camy_r  <= '0;
      camz_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      roll_r  <= '0;
      fov_r   <= FOV_RESET;
    end else if (wr) begin
      unique case (ridx)
        REG_CAM_X: camx_r  <= pwdata;
        REG_CAM_Y: camy_r  <= pwdata;
        REG_CAM_Z: camz_r  <= pwdata;
        REG_PITCH: pitch_r <= pwdata[ANG_W-1:0];
        REG_YAW:   yaw_r   <= pwdata[ANG_W-1:0];
        REG_ROLL:  roll_r  <= pwdata[ANG_W-1:0];
        REG_FOV:   fov_r   <= pwdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_CAM_X: prdata = camx_r;
      REG_CAM_Y: prdata = camy_r;
      REG_CAM_Z: prdata = camz_r;
      REG_PITCH: prdata = {16'b0, pitch_r};
      REG_YAW:   prdata = {16'b0, yaw_r};
      REG_ROLL:  prdata = {16'b0, roll_r};
      REG_FOV:   prdata = {16'b0, fov_r};
      default:   prdata = '0;
    endcase
  end

  ecp_setup #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (wr),
    .pitch (pitch_r),
    .yaw   (yaw_r),
    .roll  (roll_r),
    .fov   (fov_r),
    .busy  (setup_busy),
    .cam   (cam)
  );

  assign busy = setup_busy;

  always_comb begin
    sx = SUM_W'(pr_r[0]) + SUM_W'(pr_r[1]) + SUM_W'(pr_r[2]) + SUM_W'(17'sd32768);
    sy = SUM_W'(pr_r[3]) + SUM_W'(pr_r[4]) + SUM_W'(pr_r[5]) + SUM_W'(17'sd32768);
    sz = SUM_W'(pr_r[6]) + SUM_W'(pr_r[7]) + SUM_W'(pr_r[8]) + SUM_W'(17'sd32768);
    vx_c = sx[SUM_W-1:16];
    vy_c = sy[SUM_W-1:16];
    vz_c = sz[SUM_W-1:16];
    flo  = $signed({1'b0, cam.focal[FL_W-1:0]});
    fhi  = $signed({1'b0, cam.focal[FOC_W-1:FL_W]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= dv;
    end
    d_r[0] <= D_W'(in_data.world_x) - D_W'(camx_r);
    d_r[1] <= D_W'(in_data.world_y) - D_W'(camy_r);
    d_r[2] <= D_W'(in_data.world_z) - D_W'(camz_r);
    pr_r[0] <= d_r[0] * cam.ay0;
    pr_r[1] <= d_r[1] * cam.ay1;
    pr_r[2] <= d_r[2] * cam.ay2;
    pr_r[3] <= d_r[0] * cam.az0;
    pr_r[4] <= d_r[1] * cam.az1;
    pr_r[5] <= d_r[2] * cam.az2;
    pr_r[6] <= d_r[0] * cam.ax0;
    pr_r[7] <= d_r[1] * cam.ax1;
    pr_r[8] <= d_r[2] * cam.ax2;
    vx_r <= vx_c;
    vy_r <= vy_c;
    if (vz_c < V_W'(256)) begin
      vz3_r <= VZ_W'(256);
      cl3_r <= 1'b1;
    end else begin
      vz3_r <= VZ_W'(vz_c);
      cl3_r <= 1'b0;
    end
    pxl_r <= vx_r * flo;
    pxh_r <= vx_r * fhi;
    pyl_r <= vy_r * flo;
    pyh_r <= vy_r * fhi;
    vz4_r <= vz3_r;
    cl4_r <= cl3_r;
    nx_r  <= (N_W'(pxh_r) <<< FL_W) + N_W'(pxl_r);
    ny_r  <= (N_W'(pyh_r) <<< FL_W) + N_W'(pyl_r);
    vz5_r <= vz4_r;
    cl5_r <= cl4_r;
  end

  ecp_divpipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (v5_r),
    .nx        (nx_r),
    .ny        (ny_r),
    .vz        (vz5_r),
    .clamp_in  (cl5_r),
    .out_v     (dv),
    .qx        (qx),
    .qy        (qy),
    .clamp_out (dcl)
  );

  always_comb begin
    px = HW_S + OS_W'(qx);
    py = HH_S - OS_W'(qy);
  end

  always_ff @(posedge clk) begin
    if (px > OUT_MAX) begin
      out_r.screen_x <= OUT_W'(OUT_MAX);
    end else if (px < OUT_MIN) begin
      out_r.screen_x <= OUT_W'(OUT_MIN);
    end else begin
      out_r.screen_x <= OUT_W'(px);
    end
    if (py > OUT_MAX) begin
      out_r.screen_y <= OUT_W'(OUT_MAX);
    end else if (py < OUT_MIN) begin
      out_r.screen_y <= OUT_W'(OUT_MIN);
    end else begin
      out_r.screen_y <= OUT_W'(py);
    end
    out_r.depth_clamped <= dcl;
  end

  assign out_valid = v6_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/ecp_setup.sv]
module ecp_setup
  import ecp_pkg::*;
#(
  parameter int SCREEN_WIDTH = 1920
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [ANG_W-1:0] pitch,
  input  logic [ANG_W-1:0] yaw,
  input  logic [ANG_W-1:0] roll,
  input  logic [ANG_W-1:0] fov,
  output logic             busy,
  output cam_t             cam
);

  localparam int HW   = SCREEN_WIDTH * 128;
  localparam int HW_W = $clog2(HW + 1);
  localparam logic [HW_W-1:0] HW_V = HW_W'(HW);

  typedef enum logic [1:0] {ST_IDLE, ST_ANG, ST_MUL, ST_DIV} st_t;

  st_t                     state_r, state_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic                    flip_r, flip_nxt;
  logic signed [CX_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [CZ_W-1:0]  z_r, z_nxt;
  logic signed [AX_W-1:0]  cs_r [6];
  logic signed [AX_W-1:0]  cs_nxt [6];
  logic signed [CX_W-1:0]  fc_r, fc_nxt, fs_r, fs_nxt;
  logic signed [AX_W-1:0]  p_r [14];
  logic signed [AX_W-1:0]  p_nxt [14];
  logic [FN_W-1:0]         num_r, num_nxt, quo_r, quo_nxt;
  logic [CX_W-1:0]         rem_r, rem_nxt;
  cam_t                    cam_r, cam_nxt;

  logic [ANG_W-1:0]        fov_cl;
  logic signed [CZ_W-1:0]  a_raw, a_wrap, a_fold;
  logic                    fold;
  logic [4:0]              it;
  logic signed [CX_W-1:0]  c_sel, c_rnd, s_rnd;
  logic signed [AX_W-1:0]  ma, mb;
  logic signed [2*AX_W-1:0] prod;
  logic signed [2*AX_W-1:0] prod_rnd;
  logic [HW_W+31:0]        hwfc;
  logic [CX_W:0]           dt;

  always_comb begin
    if (fov < FOV_MIN) begin
      fov_cl = FOV_MIN;
    end else if (fov > FOV_MAX) begin
      fov_cl = FOV_MAX;
    end else begin
      fov_cl = fov;
    end
    unique case (idx_r)
      2'd0: a_raw = {{(CZ_W-ANG_W-9){pitch[ANG_W-1]}}, pitch, 9'b0};
      2'd1: a_raw = {{(CZ_W-ANG_W-9){yaw[ANG_W-1]}}, yaw, 9'b0};
      2'd2: a_raw = {{(CZ_W-ANG_W-9){roll[ANG_W-1]}}, roll, 9'b0};
      default: a_raw = {{(CZ_W-ANG_W-7){1'b0}}, fov_cl, 7'b0};
    endcase
    if (a_raw >= DEG180) begin
      a_wrap = a_raw - DEG360;
    end else if (a_raw < -DEG180) begin
      a_wrap = a_raw + DEG360;
    end else begin
      a_wrap = a_raw;
    end
    if (a_wrap > DEG90) begin
      a_fold = DEG180 - a_wrap;
      fold   = 1'b1;
    end else if (a_wrap < -DEG90) begin
      a_fold = -DEG180 - a_wrap;
      fold   = 1'b1;
    end else begin
      a_fold = a_wrap;
      fold   = 1'b0;
    end
    it    = 5'(cnt_r - 6'd1);
    c_sel = flip_r ? -x_r : x_r;
    c_rnd = (c_sel + CX_W'(15'sd8192)) >>> 14;
    s_rnd = (y_r + CX_W'(15'sd8192)) >>> 14;
    unique case (cnt_r[3:0])
      4'd0:  begin ma = cs_r[5]; mb = cs_r[1]; end
      4'd1:  begin ma = cs_r[4]; mb = cs_r[1]; end
      4'd2:  begin ma = cs_r[0]; mb = cs_r[2]; end
      4'd3:  begin ma = cs_r[0]; mb = cs_r[3]; end
      4'd4:  begin ma = p_r[0];  mb = cs_r[2]; end
      4'd5:  begin ma = cs_r[4]; mb = cs_r[3]; end
      4'd6:  begin ma = p_r[0];  mb = cs_r[3]; end
      4'd7:  begin ma = cs_r[4]; mb = cs_r[2]; end
      4'd8:  begin ma = cs_r[5]; mb = cs_r[0]; end
      4'd9:  begin ma = p_r[1];  mb = cs_r[2]; end
      4'd10: begin ma = cs_r[5]; mb = cs_r[3]; end
      4'd11: begin ma = p_r[1];  mb = cs_r[3]; end
      4'd12: begin ma = cs_r[4]; mb = cs_r[0]; end
      default: begin ma = cs_r[5]; mb = cs_r[2]; end
    endcase
    prod     = ma * mb;
    prod_rnd = (prod + (2*AX_W)'(17'sd32768)) >>> 16;
    hwfc     = HW_V * fc_r[31:0];
    dt       = {rem_r, num_r[FN_W-1]};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    flip_nxt  = flip_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    cs_nxt    = cs_r;
    fc_nxt    = fc_r;
    fs_nxt    = fs_r;
    p_nxt     = p_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cam_nxt   = cam_r;
    if (go) begin
      state_nxt = ST_ANG;
      cnt_nxt   = '0;
      idx_nxt   = '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
        end
        ST_ANG: begin
          if (cnt_r == 6'd0) begin
            x_nxt    = CORDIC_K;
            y_nxt    = '0;
            z_nxt    = a_fold;
            flip_nxt = fold;
            cnt_nxt  = cnt_r + 6'd1;
          end else if (cnt_r <= 6'(CORDIC_N)) begin
            if (z_r >= 0) begin
              x_nxt = x_r - (y_r >>> it);
              y_nxt = y_r + (x_r >>> it);
              z_nxt = z_r - atan_q16(it);
            end else begin
              x_nxt = x_r + (y_r >>> it);
              y_nxt = y_r - (x_r >>> it);
              z_nxt = z_r + atan_q16(it);
            end
            cnt_nxt = cnt_r + 6'd1;
          end else begin
            if (idx_r == 2'd3) begin
              fc_nxt    = x_r;
              fs_nxt    = (y_r < 1) ? CX_W'(1) : y_r;
              state_nxt = ST_MUL;
            end else begin
              cs_nxt[{idx_r, 1'b0}] = AX_W'(c_rnd);
              cs_nxt[{idx_r, 1'b1}] = AX_W'(s_rnd);
              idx_nxt = idx_r + 2'd1;
            end
            cnt_nxt = '0;
          end
        end
        ST_MUL: begin
          if (cnt_r < 6'd14) begin
            p_nxt[cnt_r[3:0]] = AX_W'(prod_rnd);
            cnt_nxt = cnt_r + 6'd1;
          end else begin
            cam_nxt.ax0 = p_r[2];
            cam_nxt.ax1 = p_r[3];
            cam_nxt.ax2 = cs_r[1];
            cam_nxt.ay0 = p_r[4] - p_r[5];
            cam_nxt.ay1 = p_r[6] + p_r[7];
            cam_nxt.ay2 = -p_r[8];
            cam_nxt.az0 = -(p_r[9] + p_r[10]);
            cam_nxt.az1 = p_r[13] - p_r[11];
            cam_nxt.az2 = p_r[12];
            num_nxt   = FN_W'(hwfc) + FN_W'(fs_r[CX_W-1:1]);
            rem_nxt   = '0;
            quo_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
        ST_DIV: begin
          num_nxt = {num_r[FN_W-2:0], 1'b0};
          if (dt >= {1'b0, fs_r}) begin
            rem_nxt = CX_W'(dt - {1'b0, fs_r});
            quo_nxt = {quo_r[FN_W-2:0], 1'b1};
          end else begin
            rem_nxt = CX_W'(dt);
            quo_nxt = {quo_r[FN_W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'(FN_W - 1)) begin
            cam_nxt.focal = quo_nxt[FOC_W-1:0];
            state_nxt     = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ANG;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cs_r   <= cs_nxt;
    fc_r   <= fc_nxt;
    fs_r   <= fs_nxt;
    p_r    <= p_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    cam_r  <= cam_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign cam  = cam_r;

endmodule

[hw/rtl/ecp_divpipe.sv]
module ecp_divpipe
  import ecp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_v,
  input  logic signed [N_W-1:0]  nx,
  input  logic signed [N_W-1:0]  ny,
  input  logic [VZ_W-1:0]        vz,
  input  logic                   clamp_in,
  output logic                   out_v,
  output logic signed [QS_W-1:0] qx,
  output logic signed [QS_W-1:0] qy,
  output logic                   clamp_out
);

  logic             a_v_r, b_v_r;
  logic             a_negx_r, a_negy_r, b_negx_r, b_negy_r;
  logic [N_W-1:0]   a_absx_r, a_absy_r, b_nx_r, b_ny_r;
  logic [VZ_W-1:0]  a_vz_r, b_vz_r;
  logic             a_cl_r, b_cl_r;

  logic             v_r     [QB+1];
  logic             cl_r    [QB+1];
  logic [VZ_W-1:0]  vz_r    [QB+1];
  logic             negx_r  [QB+1];
  logic             negy_r  [QB+1];
  logic             satx_r  [QB+1];
  logic             saty_r  [QB+1];
  logic [VZ_W-1:0]  remx_r  [QB+1];
  logic [VZ_W-1:0]  remy_r  [QB+1];
  logic [QB-1:0]    lowx_r  [QB+1];
  logic [QB-1:0]    lowy_r  [QB+1];
  logic [QB-1:0]    quox_r  [QB+1];
  logic [QB-1:0]    quoy_r  [QB+1];

  logic [N_W-1:0]   vz_sh;
  logic [QB:0]      magx, magy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
      v_r[0] <= b_v_r;
    end
    a_negx_r <= nx[N_W-1];
    a_negy_r <= ny[N_W-1];
    a_absx_r <= nx[N_W-1] ? N_W'(-nx) : N_W'(nx);
    a_absy_r <= ny[N_W-1] ? N_W'(-ny) : N_W'(ny);
    a_vz_r   <= vz;
    a_cl_r   <= clamp_in;
    b_negx_r <= a_negx_r;
    b_negy_r <= a_negy_r;
    b_nx_r   <= a_absx_r + N_W'(a_vz_r[VZ_W-1:1]);
    b_ny_r   <= a_absy_r + N_W'(a_vz_r[VZ_W-1:1]);
    b_vz_r   <= a_vz_r;
    b_cl_r   <= a_cl_r;
  end

  assign vz_sh = N_W'({b_vz_r, {QB{1'b0}}});

  always_ff @(posedge clk) begin
    cl_r[0]   <= b_cl_r;
    vz_r[0]   <= b_vz_r;
    negx_r[0] <= b_negx_r;
    negy_r[0] <= b_negy_r;
    satx_r[0] <= (b_nx_r >= vz_sh);
    saty_r[0] <= (b_ny_r >= vz_sh);
    remx_r[0] <= b_nx_r[QB +: VZ_W];
    remy_r[0] <= b_ny_r[QB +: VZ_W];
    lowx_r[0] <= b_nx_r[QB-1:0];
    lowy_r[0] <= b_ny_r[QB-1:0];
    quox_r[0] <= '0;
    quoy_r[0] <= '0;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [VZ_W:0] tx, ty;
    assign tx = {remx_r[k-1], lowx_r[k-1][QB-1]};
    assign ty = {remy_r[k-1], lowy_r[k-1][QB-1]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
      cl_r[k]   <= cl_r[k-1];
      vz_r[k]   <= vz_r[k-1];
      negx_r[k] <= negx_r[k-1];
      negy_r[k] <= negy_r[k-1];
      satx_r[k] <= satx_r[k-1];
      saty_r[k] <= saty_r[k-1];
      lowx_r[k] <= {lowx_r[k-1][QB-2:0], 1'b0};
      lowy_r[k] <= {lowy_r[k-1][QB-2:0], 1'b0};
      if (tx >= {1'b0, vz_r[k-1]}) begin
        remx_r[k] <= VZ_W'(tx - {1'b0, vz_r[k-1]});
        quox_r[k] <= {quox_r[k-1][QB-2:0], 1'b1};
      end else begin
        remx_r[k] <= VZ_W'(tx);
        quox_r[k] <= {quox_r[k-1][QB-2:0], 1'b0};
      end
      if (ty >= {1'b0, vz_r[k-1]}) begin
        remy_r[k] <= VZ_W'(ty - {1'b0, vz_r[k-1]});
        quoy_r[k] <= {quoy_r[k-1][QB-2:0], 1'b1};
      end else begin
        remy_r[k] <= VZ_W'(ty);
        quoy_r[k] <= {quoy_r[k-1][QB-2:0], 1'b0};
      end
    end
  end

  assign magx      = satx_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, quox_r[QB]};
  assign magy      = saty_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, quoy_r[QB]};
  assign qx        = negx_r[QB] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
  assign qy        = negy_r[QB] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
  assign out_v     = v_r[QB];
  assign clamp_out = cl_r[QB];

endmodule
